// ===== rtl/omi_pkg.sv =====
`default_nettype none
package omi_pkg;

  localparam int QW = 50;
  localparam int RW = 35;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_SETV = 2'd2;
  localparam logic [1:0] CMD_SETP = 2'd3;

  localparam logic [2:0] CFG_MAX_SPEED     = 3'd0;
  localparam logic [2:0] CFG_POWER_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_FRICTION      = 3'd2;
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd4;

  localparam logic [25:0] MAX_SPEED_RST   = 26'd6553600;
  localparam logic [23:0] POWER_LIMIT_RST = 24'd65536;
  localparam logic [23:0] FRICTION_RST    = 24'd98304;
  localparam logic [9:0]  SCREEN_W_RST    = 10'd80;
  localparam logic [9:0]  SCREEN_H_RST    = 10'd25;

  localparam logic [31:0] TINY_LEN = 32'd7;
  localparam logic signed [17:0] HEADING_Y_RST = -18'sd65536;

  localparam logic [5:0] ROOT_TOP = 6'd31;
  localparam logic [5:0] LIM_TOP  = 6'd24;
  localparam logic [5:0] MOVE_TOP = 6'd49;
  localparam logic [5:0] HEAD_TOP = 6'd16;

  typedef enum logic [5:0] {
    ST_IDLE, ST_ADD, ST_SETV, ST_SETP, ST_LOAD, ST_SQX, ST_SQY, ST_ROOT, ST_ROOTW,
    ST_LIMX, ST_LIMXD, ST_LIMXW, ST_LIMY, ST_LIMYD, ST_LIMYW,
    ST_MOVE, ST_MOVEM, ST_MOVEX, ST_MOVEXD, ST_MOVEXW, ST_MOVEY, ST_MOVEYD, ST_MOVEYW,
    ST_FRIC, ST_FRICK, ST_FRICX, ST_FRICY, ST_FRICW, ST_FINAL,
    ST_HEADX, ST_HEADXW, ST_HEADY, ST_HEADYW, ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic        sqrt;
    logic [63:0] src;
    logic [31:0] den;
    logic [5:0]  top;
  } unit_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/omi_unit.sv =====
`default_nettype none
module omi_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire omi_pkg::unit_req_t         req,
  output logic [omi_pkg::QW-1:0]          result,
  output logic                            done,
  input  wire logic [31:0]                mul_a,
  input  wire logic [31:0]                mul_b,
  output logic [63:0]                     mul_p
);

  logic                     active;
  logic                     sqrt_mode;
  logic [5:0]               cnt;
  logic [63:0]              src;
  logic [31:0]              den;
  logic [omi_pkg::RW-1:0]   rem;
  logic [omi_pkg::QW-1:0]   q;
  logic [omi_pkg::RW-1:0]   rem_sh;
  logic [omi_pkg::RW-1:0]   trial;
  logic [omi_pkg::RW-1:0]   diff;
  logic                     ge;

  // one quotient or root bit per cycle, shared compare-subtract
  always_comb begin
    if (sqrt_mode) begin
      rem_sh = {rem[omi_pkg::RW-3:0], src[{cnt[4:0], 1'b1}], src[{cnt[4:0], 1'b0}]};
      trial  = {q[omi_pkg::RW-3:0], 2'b01};
    end else begin
      rem_sh = {rem[omi_pkg::RW-2:0], src[cnt]};
      trial  = omi_pkg::RW'(den);
    end
    ge   = rem_sh >= trial;
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
      end else if (active && cnt == 6'd0) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sqrt_mode <= req.sqrt;
      src       <= req.src;
      den       <= req.den;
      cnt       <= req.top;
      q         <= '0;
      if (req.sqrt) begin
        rem <= '0;
      end else begin
        rem <= omi_pkg::RW'(req.src >> ({1'b0, req.top} + 7'd1));
      end
    end else if (active) begin
      rem <= ge ? diff : rem_sh;
      q   <= {q[omi_pkg::QW-2:0], ge};
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  assign result = q;

endmodule
`default_nettype wire

// ===== rtl/omi_core.sv =====
`default_nettype none
module omi_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [1:0]                command,
  input  wire logic [15:0]               time_step,
  input  wire logic signed [31:0]        vec_x,
  input  wire logic signed [31:0]        vec_y,
  input  wire logic [25:0]               max_speed,
  input  wire logic [23:0]               power_limit,
  input  wire logic [23:0]               friction,
  input  wire logic [9:0]                screen_width,
  input  wire logic [9:0]                screen_height,
  input  wire logic                      out_free,
  output logic                           idle,
  output logic                           finish,
  output logic signed [31:0]             position_x,
  output logic signed [31:0]             position_y,
  output logic signed [31:0]             velocity_x,
  output logic signed [31:0]             velocity_y,
  output logic signed [17:0]             heading_x,
  output logic signed [17:0]             heading_y,
  output omi_pkg::unit_req_t             req,
  input  wire logic [omi_pkg::QW-1:0]    unit_result,
  input  wire logic                      unit_done,
  output logic [31:0]                    mul_a,
  output logic [31:0]                    mul_b,
  input  wire logic [63:0]               mul_p
);

  omi_pkg::state_t state, state_next;

  logic [1:0]               cmd_r;
  logic [15:0]              dt;
  logic signed [31:0]       vx_r, vy_r;
  logic [31:0]              ax, ay;
  logic                     sx, sy;
  logic [23:0]              lim;
  logic [63:0]              acc;
  logic [31:0]              len;
  logic [25:0]              m;
  logic [23:0]              k;
  logic [omi_pkg::QW-1:0]   dx, dy;
  logic [31:0]              fx, fy;
  logic [31:0]              root;

  logic signed [35:0]       add_x, add_y;
  logic signed [51:0]       dxs, dys, px, py, bx, by;
  logic signed [33:0]       tx, ty;
  logic signed [31:0]       nvx, nvy;
  logic signed [17:0]       q18;

  assign root = unit_result[31:0];
  assign q18  = unit_result[17:0];

  always_comb begin
    state_next = state;
    case (state)
      omi_pkg::ST_IDLE: begin
        if (start) begin
          case (command)
            omi_pkg::CMD_TICK: state_next = omi_pkg::ST_LOAD;
            omi_pkg::CMD_ADD:  state_next = omi_pkg::ST_ADD;
            omi_pkg::CMD_SETV: state_next = omi_pkg::ST_SETV;
            default:           state_next = omi_pkg::ST_SETP;
          endcase
        end
      end
      omi_pkg::ST_ADD:    state_next = omi_pkg::ST_LOAD;
      omi_pkg::ST_SETV:   state_next = omi_pkg::ST_DONE;
      omi_pkg::ST_SETP:   state_next = omi_pkg::ST_DONE;
      omi_pkg::ST_LOAD:   state_next = omi_pkg::ST_SQX;
      omi_pkg::ST_SQX:    state_next = omi_pkg::ST_SQY;
      omi_pkg::ST_SQY:    state_next = omi_pkg::ST_ROOT;
      omi_pkg::ST_ROOT:   state_next = omi_pkg::ST_ROOTW;
      omi_pkg::ST_ROOTW: begin
        if (unit_done) begin
          if (cmd_r == omi_pkg::CMD_ADD) begin
            state_next = (root == 32'd0) ? omi_pkg::ST_DONE : omi_pkg::ST_HEADX;
          end else if (root < omi_pkg::TINY_LEN) begin
            state_next = omi_pkg::ST_MOVE;
          end else if (root > {8'd0, lim}) begin
            state_next = omi_pkg::ST_LIMX;
          end else begin
            state_next = omi_pkg::ST_MOVE;
          end
        end
      end
      omi_pkg::ST_LIMX:   state_next = omi_pkg::ST_LIMXD;
      omi_pkg::ST_LIMXD:  state_next = omi_pkg::ST_LIMXW;
      omi_pkg::ST_LIMXW:  if (unit_done) state_next = omi_pkg::ST_LIMY;
      omi_pkg::ST_LIMY:   state_next = omi_pkg::ST_LIMYD;
      omi_pkg::ST_LIMYD:  state_next = omi_pkg::ST_LIMYW;
      omi_pkg::ST_LIMYW:  if (unit_done) state_next = omi_pkg::ST_MOVE;
      omi_pkg::ST_MOVE:   state_next = omi_pkg::ST_MOVEM;
      omi_pkg::ST_MOVEM:  state_next = omi_pkg::ST_MOVEX;
      omi_pkg::ST_MOVEX:  state_next = omi_pkg::ST_MOVEXD;
      omi_pkg::ST_MOVEXD: state_next = omi_pkg::ST_MOVEXW;
      omi_pkg::ST_MOVEXW: if (unit_done) state_next = omi_pkg::ST_MOVEY;
      omi_pkg::ST_MOVEY:  state_next = omi_pkg::ST_MOVEYD;
      omi_pkg::ST_MOVEYD: state_next = omi_pkg::ST_MOVEYW;
      omi_pkg::ST_MOVEYW: if (unit_done) state_next = omi_pkg::ST_FRIC;
      omi_pkg::ST_FRIC:   state_next = omi_pkg::ST_FRICK;
      omi_pkg::ST_FRICK:  state_next = omi_pkg::ST_FRICX;
      omi_pkg::ST_FRICX:  state_next = omi_pkg::ST_FRICY;
      omi_pkg::ST_FRICY:  state_next = omi_pkg::ST_FRICW;
      omi_pkg::ST_FRICW:  state_next = omi_pkg::ST_FINAL;
      omi_pkg::ST_FINAL:  state_next = omi_pkg::ST_DONE;
      omi_pkg::ST_HEADX:  state_next = omi_pkg::ST_HEADXW;
      omi_pkg::ST_HEADXW: if (unit_done) state_next = omi_pkg::ST_HEADY;
      omi_pkg::ST_HEADY:  state_next = omi_pkg::ST_HEADYW;
      omi_pkg::ST_HEADYW: if (unit_done) state_next = omi_pkg::ST_DONE;
      omi_pkg::ST_DONE:   if (out_free) state_next = omi_pkg::ST_IDLE;
      default:            state_next = omi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req    = '0;
    mul_a  = '0;
    mul_b  = '0;
    idle   = state == omi_pkg::ST_IDLE;
    finish = (state == omi_pkg::ST_DONE) && out_free;
    case (state)
      omi_pkg::ST_SQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      omi_pkg::ST_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      omi_pkg::ST_ROOT: begin
        req.start = 1'b1;
        req.sqrt  = 1'b1;
        req.src   = acc + mul_p;
        req.top   = omi_pkg::ROOT_TOP;
      end
      omi_pkg::ST_LIMX: begin
        mul_a = ax;
        mul_b = {8'd0, lim};
      end
      omi_pkg::ST_LIMY: begin
        mul_a = ay;
        mul_b = {8'd0, lim};
      end
      omi_pkg::ST_LIMXD, omi_pkg::ST_LIMYD: begin
        req.start = 1'b1;
        req.src   = mul_p;
        req.den   = len;
        req.top   = omi_pkg::LIM_TOP;
      end
      omi_pkg::ST_MOVE: begin
        mul_a = {6'd0, max_speed};
        mul_b = {16'd0, dt};
      end
      omi_pkg::ST_MOVEX: begin
        mul_a = ax;
        mul_b = {6'd0, m};
      end
      omi_pkg::ST_MOVEY: begin
        mul_a = ay;
        mul_b = {6'd0, m};
      end
      omi_pkg::ST_MOVEXD, omi_pkg::ST_MOVEYD: begin
        req.start = 1'b1;
        req.src   = mul_p;
        req.den   = {8'd0, lim};
        req.top   = omi_pkg::MOVE_TOP;
      end
      omi_pkg::ST_FRIC: begin
        mul_a = {8'd0, friction};
        mul_b = {16'd0, dt};
      end
      omi_pkg::ST_FRICX: begin
        mul_a = ax;
        mul_b = {8'd0, k};
      end
      omi_pkg::ST_FRICY: begin
        mul_a = ay;
        mul_b = {8'd0, k};
      end
      omi_pkg::ST_HEADX: begin
        req.start = 1'b1;
        req.src   = {16'd0, ax, 16'd0};
        req.den   = len;
        req.top   = omi_pkg::HEAD_TOP;
      end
      omi_pkg::ST_HEADY: begin
        req.start = 1'b1;
        req.src   = {16'd0, ay, 16'd0};
        req.den   = len;
        req.top   = omi_pkg::HEAD_TOP;
      end
      default: begin
      end
    endcase
  end

  // add-power sums and end-of-tick update
  always_comb begin
    add_x = 36'(velocity_x) + 36'(vx_r);
    add_y = 36'(velocity_y) + 36'(vy_r);
    dxs   = sx ? -$signed({2'b00, dx}) : $signed({2'b00, dx});
    dys   = sy ? -$signed({2'b00, dy}) : $signed({2'b00, dy});
    px    = 52'(position_x) + dxs;
    py    = 52'(position_y) + dys;
    bx    = $signed({26'd0, screen_width, 16'd0});
    by    = $signed({26'd0, screen_height, 16'd0});
    tx    = $signed({2'b00, ax}) - $signed({2'b00, fx});
    ty    = $signed({2'b00, ay}) - $signed({2'b00, fy});
    nvx   = omi_pkg::sat32(sx ? -36'(tx) : 36'(tx));
    nvy   = omi_pkg::sat32(sy ? -36'(ty) : 36'(ty));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= omi_pkg::ST_IDLE;
      position_x <= '0;
      position_y <= '0;
      velocity_x <= '0;
      velocity_y <= '0;
      heading_x  <= '0;
      heading_y  <= omi_pkg::HEADING_Y_RST;
    end else begin
      state <= state_next;
      case (state)
        omi_pkg::ST_ADD: begin
          velocity_x <= omi_pkg::sat32(add_x);
          velocity_y <= omi_pkg::sat32(add_y);
        end
        omi_pkg::ST_SETV: begin
          velocity_x <= vx_r;
          velocity_y <= vy_r;
        end
        omi_pkg::ST_SETP: begin
          position_x <= vx_r;
          position_y <= vy_r;
        end
        omi_pkg::ST_ROOTW: begin
          if (unit_done && cmd_r == omi_pkg::CMD_ADD && root == 32'd0) begin
            heading_x <= '0;
            heading_y <= '0;
          end
        end
        omi_pkg::ST_HEADXW: if (unit_done) heading_x <= sx ? -q18 : q18;
        omi_pkg::ST_HEADYW: if (unit_done) heading_y <= sy ? -q18 : q18;
        omi_pkg::ST_FINAL: begin
          if (px < 52'sd0) begin
            position_x <= '0;
            velocity_x <= '0;
          end else if (px > bx) begin
            position_x <= bx[31:0];
            velocity_x <= '0;
          end else begin
            position_x <= px[31:0];
            velocity_x <= nvx;
          end
          if (py < 52'sd0) begin
            position_y <= '0;
            velocity_y <= '0;
          end else if (py > by) begin
            position_y <= by[31:0];
            velocity_y <= '0;
          end else begin
            position_y <= py[31:0];
            velocity_y <= nvy;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      omi_pkg::ST_IDLE: begin
        if (start) begin
          cmd_r <= command;
          dt    <= time_step;
          vx_r  <= vec_x;
          vy_r  <= vec_y;
        end
      end
      omi_pkg::ST_LOAD: begin
        ax  <= velocity_x[31] ? 32'(-velocity_x) : velocity_x;
        ay  <= velocity_y[31] ? 32'(-velocity_y) : velocity_y;
        sx  <= velocity_x[31];
        sy  <= velocity_y[31];
        lim <= (power_limit == 24'd0) ? 24'd1 : power_limit;
      end
      omi_pkg::ST_SQY: acc <= mul_p;
      omi_pkg::ST_ROOTW: begin
        if (unit_done) begin
          len <= root;
          if (cmd_r == omi_pkg::CMD_TICK && root < omi_pkg::TINY_LEN) begin
            ax <= '0;
            ay <= '0;
          end
        end
      end
      omi_pkg::ST_LIMXW:  if (unit_done) ax <= root;
      omi_pkg::ST_LIMYW:  if (unit_done) ay <= root;
      omi_pkg::ST_MOVEM:  m <= mul_p[41:16];
      omi_pkg::ST_MOVEXW: if (unit_done) dx <= unit_result;
      omi_pkg::ST_MOVEYW: if (unit_done) dy <= unit_result;
      omi_pkg::ST_FRICK:  k <= mul_p[39:16];
      omi_pkg::ST_FRICY:  fx <= mul_p[47:16];
      omi_pkg::ST_FRICW:  fy <= mul_p[47:16];
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/object_motion_integrator_top.sv =====
`default_nettype none
// 2D motion integrator with position, velocity and heading state, all fixed point.
// input channel: in_valid/in_stall carry command, time_step, vec_x, vec_y.
// a request is taken when in_valid is high and in_stall is low; in_stall stays
// high while a request is being worked on.
// output channel: out_valid/out_stall carry the state after each request,
// exactly one result per request; the result register holds while out_stall is high.
// a new request may be taken while a result waits; its result is held back
// until the output register is free.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// it is to be written only while idle; the block itself does not enforce this.
// set velocity or position writes the state; add power takes a square root and, for
// a nonzero speed, two divides for the heading; tick takes a square root, two divides
// to move and two more when the velocity must be limited. The sequencer is idle again
// once the result is registered. The arithmetic uses the shared divide and square root
// unit, one bit per cycle, and a single 32x32 multiplier reused by the sequencer.
// reset: synchronous; position and velocity clear, heading becomes (0, -1),
// config registers take their defaults.
module object_motion_integrator_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic [15:0]        time_step,
  input  wire logic signed [31:0] vec_x,
  input  wire logic signed [31:0] vec_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      power_x,
  output logic signed [31:0]      power_y,
  output logic signed [17:0]      dir_x,
  output logic signed [17:0]      dir_y,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [25:0]        cfg_data
);

  logic [25:0] max_speed;
  logic [23:0] power_limit;
  logic [23:0] friction;
  logic [9:0]  screen_width;
  logic [9:0]  screen_height;

  logic                     core_idle;
  logic                     finish;
  logic                     out_free;
  logic signed [31:0]       position_x, position_y, velocity_x, velocity_y;
  logic signed [17:0]       heading_x, heading_y;
  omi_pkg::unit_req_t       req;
  logic [omi_pkg::QW-1:0]   unit_result;
  logic                     u_done;
  logic [31:0]              mul_a, mul_b;
  logic [63:0]              mul_p;

  assign cfg_ready = 1'b1;
  assign in_stall  = !core_idle;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed     <= omi_pkg::MAX_SPEED_RST;
      power_limit   <= omi_pkg::POWER_LIMIT_RST;
      friction      <= omi_pkg::FRICTION_RST;
      screen_width  <= omi_pkg::SCREEN_W_RST;
      screen_height <= omi_pkg::SCREEN_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        omi_pkg::CFG_MAX_SPEED:     max_speed     <= cfg_data;
        omi_pkg::CFG_POWER_LIMIT:   power_limit   <= cfg_data[23:0];
        omi_pkg::CFG_FRICTION:      friction      <= cfg_data[23:0];
        omi_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[9:0];
        omi_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  omi_core u_core (
    .clk           (clk),
    .rst           (rst),
    .start         (in_valid && !in_stall),
    .command       (command),
    .time_step     (time_step),
    .vec_x         (vec_x),
    .vec_y         (vec_y),
    .max_speed     (max_speed),
    .power_limit   (power_limit),
    .friction      (friction),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_free      (out_free),
    .idle          (core_idle),
    .finish        (finish),
    .position_x    (position_x),
    .position_y    (position_y),
    .velocity_x    (velocity_x),
    .velocity_y    (velocity_y),
    .heading_x     (heading_x),
    .heading_y     (heading_y),
    .req           (req),
    .unit_result   (unit_result),
    .unit_done     (u_done),
    .mul_a         (mul_a),
    .mul_b         (mul_b),
    .mul_p         (mul_p)
  );

  omi_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .result (unit_result),
    .done   (u_done),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .mul_p  (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      pos_x   <= position_x;
      pos_y   <= position_y;
      power_x <= velocity_x;
      power_y <= velocity_y;
      dir_x   <= heading_x;
      dir_y   <= heading_y;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while not busy afterwards");

  a_unit_done_busy: assert property (@(posedge clk) disable iff (rst)
    u_done |-> in_stall)
    else $error("arithmetic unit finished while idle");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result shown before the sequencer returned to idle");
`endif

endmodule
`default_nettype wire

// ===== test/tb_object_motion_integrator_top.sv =====
`default_nettype none
module tb_object_motion_integrator_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] dt;
    logic [31:0] vx;
    logic [31:0] vy;
  } motion_req_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [17:0] hx;
    logic [17:0] hy;
  } motion_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic [15:0] time_step = '0;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, power_x, power_y;
  logic signed [17:0] dir_x, dir_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [25:0] cfg_data = '0;

  object_motion_integrator_top u_dut (.*);

  always #5 clk = ~clk;

  // model state
  longint unsigned m_speed, m_limit, m_fric, m_width, m_height;
  longint m_px, m_py, m_vx, m_vy, m_hx, m_hy;

  motion_req_t pending_q[$];
  motion_state_t expected_q[$];
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  longint cycles = 0;

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint signed_of(longint r, longint unsigned m);
    return r < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat_i32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned speed_len();
    longint unsigned ax, ay;
    ax = magn(m_vx);
    ay = magn(m_vy);
    return int_sqrt(ax * ax + ay * ay);
  endfunction

  task automatic clamp(inout longint p, inout longint v, input longint unsigned cells);
    longint bound;
    bound = longint'(cells << 16);
    if (p < 0) begin
      p = 0;
      v = 0;
    end else if (p > bound) begin
      p = bound;
      v = 0;
    end
  endtask

  task automatic advance_motion(motion_req_t r);
    longint unsigned lim, len, m, k, dt;
    longint ox, oy;
    motion_state_t e;
    ox = longint'(signed'(r.vx));
    oy = longint'(signed'(r.vy));
    dt = 64'(r.dt);
    case (r.cmd)
      omi_pkg::CMD_TICK: begin
        lim = m_limit != 0 ? m_limit : 1;
        len = speed_len();
        if (len < 7) begin
          m_vx = 0;
          m_vy = 0;
        end else if (len > lim) begin
          m_vx = signed_of(m_vx, magn(m_vx) * lim / len);
          m_vy = signed_of(m_vy, magn(m_vy) * lim / len);
        end
        m = (m_speed * dt) >> 16;
        m_px += signed_of(m_vx, magn(m_vx) * m / lim);
        m_py += signed_of(m_vy, magn(m_vy) * m / lim);
        k = (m_fric * dt) >> 16;
        m_vx = sat_i32(m_vx - signed_of(m_vx, (magn(m_vx) * k) >> 16));
        m_vy = sat_i32(m_vy - signed_of(m_vy, (magn(m_vy) * k) >> 16));
        clamp(m_px, m_vx, m_width);
        clamp(m_py, m_vy, m_height);
      end
      omi_pkg::CMD_ADD: begin
        m_vx = sat_i32(m_vx + ox);
        m_vy = sat_i32(m_vy + oy);
        len = speed_len();
        if (len == 0) begin
          m_hx = 0;
          m_hy = 0;
        end else begin
          m_hx = signed_of(m_vx, magn(m_vx) * 65536 / len);
          m_hy = signed_of(m_vy, magn(m_vy) * 65536 / len);
        end
      end
      omi_pkg::CMD_SETV: begin
        m_vx = ox;
        m_vy = oy;
      end
      default: begin
        m_px = ox;
        m_py = oy;
      end
    endcase
    e.px = m_px[31:0];
    e.py = m_py[31:0];
    e.wx = m_vx[31:0];
    e.wy = m_vy[31:0];
    e.hx = m_hx[17:0];
    e.hy = m_hy[17:0];
    expected_q.push_back(e);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [25:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      omi_pkg::CFG_MAX_SPEED: m_speed = 64'(val);
      omi_pkg::CFG_POWER_LIMIT: m_limit = 64'(val[23:0]);
      omi_pkg::CFG_FRICTION: m_fric = 64'(val[23:0]);
      omi_pkg::CFG_SCREEN_WIDTH: m_width = 64'(val[9:0]);
      omi_pkg::CFG_SCREEN_HEIGHT: m_height = 64'(val[9:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_req(logic [1:0] c, logic [15:0] d, logic [31:0] x, logic [31:0] y);
    motion_req_t r;
    r.cmd = c;
    r.dt = d;
    r.vx = x;
    r.vy = y;
    pending_q.push_back(r);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 262144)) - 131072);
      2: return 32'($signed($urandom_range(0, 4096)) - 2048);
      3: return $urandom_range(0, 90) << 16;
      4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 20)) - 10);
    endcase
  endfunction

  task automatic random_phase(int n);
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 9);
      if (c < 5) queue_req(omi_pkg::CMD_TICK, $urandom_range(0, 3) == 0 ? 16'($urandom()) :
                           16'($urandom_range(0, 4000)), $urandom(), $urandom());
      else if (c < 8) queue_req(omi_pkg::CMD_ADD, 16'($urandom()), rand_q16(), rand_q16());
      else if (c == 8) queue_req(omi_pkg::CMD_SETV, 16'($urandom()), rand_q16(), rand_q16());
      else queue_req(omi_pkg::CMD_SETP, 16'($urandom()), rand_q16(), rand_q16());
    end
    drain();
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_valid <= 1'b1;
        command <= pending_q[0].cmd;
        time_step <= pending_q[0].dt;
        vec_x <= pending_q[0].vx;
        vec_y <= pending_q[0].vy;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
      stall_phase <= (stall_phase + 1) % 37;
      out_stall <= (stall_phase < 12) ? ($urandom_range(0, 2) != 0) : 1'b0;
    end
  end

  // accept and predict
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      advance_motion(pending_q.pop_front());
    end
  end

  // monitor
  always @(posedge clk) begin
    motion_state_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (pos_x !== e.px) begin
          $error("pos_x expected %0d actual %0d", $signed(e.px), pos_x);
          errors++;
        end
        if (pos_y !== e.py) begin
          $error("pos_y expected %0d actual %0d", $signed(e.py), pos_y);
          errors++;
        end
        if (power_x !== e.wx) begin
          $error("power_x expected %0d actual %0d", $signed(e.wx), power_x);
          errors++;
        end
        if (power_y !== e.wy) begin
          $error("power_y expected %0d actual %0d", $signed(e.wy), power_y);
          errors++;
        end
        if (dir_x !== e.hx) begin
          $error("dir_x expected %0d actual %0d", $signed(e.hx), dir_x);
          errors++;
        end
        if (dir_y !== e.hy) begin
          $error("dir_y expected %0d actual %0d", $signed(e.hy), dir_y);
          errors++;
        end
      end
    end
    if (cycles > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    m_speed = 64'(omi_pkg::MAX_SPEED_RST);
    m_limit = 64'(omi_pkg::POWER_LIMIT_RST);
    m_fric = 64'(omi_pkg::FRICTION_RST);
    m_width = 64'(omi_pkg::SCREEN_W_RST);
    m_height = 64'(omi_pkg::SCREEN_H_RST);
    m_px = 0;
    m_py = 0;
    m_vx = 0;
    m_vy = 0;
    m_hx = 0;
    m_hy = -65536;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: defaults
    queue_req(omi_pkg::CMD_TICK, 16'd1000, 32'd0, 32'd0);
    queue_req(omi_pkg::CMD_ADD, 16'hffff, 32'd0, 32'd0);
    queue_req(omi_pkg::CMD_ADD, 16'd0, 32'd3, 32'd2);
    queue_req(omi_pkg::CMD_TICK, 16'd1000, 32'd0, 32'd0);
    queue_req(omi_pkg::CMD_ADD, 16'd0, 32'h7fffffff, 32'h80000000);
    queue_req(omi_pkg::CMD_ADD, 16'd0, 32'h7fffffff, 32'h80000000);
    queue_req(omi_pkg::CMD_SETP, 16'd0, 32'h80000000, 32'h7fffffff);
    queue_req(omi_pkg::CMD_TICK, 16'hffff, 32'hffffffff, 32'hffffffff);
    queue_req(omi_pkg::CMD_SETP, 16'd0, 32'd40 << 16, 32'd10 << 16);
    queue_req(omi_pkg::CMD_SETV, 16'd0, 32'h00030000, 32'hfffe0000);
    queue_req(omi_pkg::CMD_TICK, 16'd1092, 32'd0, 32'd0);
    queue_req(omi_pkg::CMD_SETV, 16'd0, 32'h7fffffff, 32'h80000000);
    queue_req(omi_pkg::CMD_TICK, 16'd0, 32'd0, 32'd0);
    queue_req(omi_pkg::CMD_ADD, 16'd0, 32'hffff0000, 32'd0);
    queue_req(omi_pkg::CMD_TICK, 16'hffff, 32'd0, 32'd0);
    drain();

    // extremes: zero limit, huge friction, zero screen width
    write_reg(omi_pkg::CFG_POWER_LIMIT, 26'd0);
    write_reg(omi_pkg::CFG_FRICTION, 26'hffffff);
    write_reg(omi_pkg::CFG_MAX_SPEED, 26'h3ffffff);
    write_reg(omi_pkg::CFG_SCREEN_WIDTH, 26'd0);
    write_reg(omi_pkg::CFG_SCREEN_HEIGHT, 26'd1023);
    queue_req(omi_pkg::CMD_SETP, 16'd0, 32'd0, 32'd5 << 16);
    queue_req(omi_pkg::CMD_SETV, 16'd0, 32'd100, 32'hffffff00);
    queue_req(omi_pkg::CMD_TICK, 16'h8000, 32'd0, 32'd0);
    queue_req(omi_pkg::CMD_SETV, 16'd0, 32'd5000, 32'd70000);
    queue_req(omi_pkg::CMD_TICK, 16'hffff, 32'd0, 32'd0);
    queue_req(omi_pkg::CMD_ADD, 16'd0, 32'd1, 32'd1);
    drain();
    random_phase(150);

    write_reg(omi_pkg::CFG_POWER_LIMIT, 26'hffffff);
    write_reg(omi_pkg::CFG_FRICTION, 26'd0);
    write_reg(omi_pkg::CFG_MAX_SPEED, 26'd0);
    write_reg(omi_pkg::CFG_SCREEN_WIDTH, 26'd1023);
    write_reg(omi_pkg::CFG_SCREEN_HEIGHT, 26'd0);
    random_phase(150);

    write_reg(omi_pkg::CFG_POWER_LIMIT, 26'd1);
    write_reg(omi_pkg::CFG_FRICTION, 26'h20000);
    write_reg(omi_pkg::CFG_MAX_SPEED, 26'd65536);
    write_reg(omi_pkg::CFG_SCREEN_WIDTH, 26'd200);
    write_reg(omi_pkg::CFG_SCREEN_HEIGHT, 26'd100);
    write_reg(3'd7, 26'h3ffffff);
    random_phase(150);

    for (int p = 0; p < 2; p++) begin
      write_reg(omi_pkg::CFG_POWER_LIMIT, 26'($urandom_range(1, 24'hffffff)));
      write_reg(omi_pkg::CFG_FRICTION, 26'($urandom_range(0, 24'hffffff)));
      write_reg(omi_pkg::CFG_MAX_SPEED, 26'($urandom_range(0, 26'h3ffffff)));
      write_reg(omi_pkg::CFG_SCREEN_WIDTH, 26'($urandom_range(0, 1023)));
      write_reg(omi_pkg::CFG_SCREEN_HEIGHT, 26'($urandom_range(0, 1023)));
      random_phase(170);
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
